>>> rtl/qcg_pkg.sv
// Package for the quadratic conjugate gradient unit: payload and command types,
// word widths, fixed-point helpers and the controller microprogram. No dependencies.
package qcg_pkg;

  localparam int MAX_ITERATIONS = 64;
  localparam int IT_W   = 7;             // iteration count and limit
  localparam int WIDE_W = 50;            // wide Q16.16 sums (dot products, gradient)
  localparam int NUM_W  = WIDE_W + 16;   // divider numerator after the Q16 shift
  localparam int DCNT_W = $clog2(NUM_W);
  localparam int PC_W   = 7;
  localparam int CFG_W  = 32;
  localparam int CIDX_W = 3;

  // microprogram entry points
  localparam logic [PC_W-1:0] PC_ITER = PC_W'(12);
  localparam logic [PC_W-1:0] PC_VAL  = PC_W'(67);

  typedef enum logic [CIDX_W-1:0] {
    REG_COEF_A          = 3'd0,
    REG_COEF_B          = 3'd1,
    REG_COEF_C          = 3'd2,
    REG_COEF_D          = 3'd3,
    REG_COEF_E          = 3'd4,
    REG_COEF_F          = 3'd5,
    REG_ITERATION_LIMIT = 3'd6,
    REG_TOLERANCE       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] start_x1;
    logic signed [31:0] start_x2;
  } in_t;

  typedef struct packed {
    logic [IT_W-1:0]    iteration;
    logic signed [31:0] point_x1;
    logic signed [31:0] point_x2;
    logic signed [31:0] step_length;
    logic               converged;
    logic signed [31:0] minimum_value;
    logic               fault;
    logic               last;
  } out_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] e;
    logic signed [31:0] f;
    logic [30:0]        tol;
  } coef_t;

  typedef enum logic [3:0] {
    UOP_NOP, UOP_LDA, UOP_MUL, UOP_ADD, UOP_ST, UOP_STGG, UOP_STDEN,
    UOP_DIVB, UOP_DIVA, UOP_CHK, UOP_EMIT
  } uop_e;

  typedef enum logic [4:0] {
    SEL_ZERO, SEL_X1, SEL_X2, SEL_G1, SEL_G2, SEL_D1, SEL_D2, SEL_H1, SEL_H2,
    SEL_BETA, SEL_ALPHA, SEL_CA, SEL_CB, SEL_CC, SEL_CD, SEL_CE, SEL_CF
  } opsel_e;

  typedef enum logic [3:0] {
    DST_X1, DST_X2, DST_G1, DST_G2, DST_D1, DST_D2, DST_H1, DST_H2,
    DST_BETA, DST_MINV
  } dst_e;

  typedef struct packed {
    uop_e   op;
    opsel_e a;
    opsel_e b;
    dst_e   dst;
    logic   dbl;   // add the product twice
    logic   neg;   // load the negated operand
  } uinst_t;

  typedef struct packed {
    uinst_t u;
    logic   first;  // first iteration: beta is zero
    logic   load;   // take a new start point
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic conv;
  } status_t;

  typedef struct packed {
    logic            emit;
    logic [IT_W-1:0] iteration;
    logic            converged;
    logic            last;
  } emit_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  // Q16.16 product, rounded half up
  function automatic logic signed [WIDE_W-1:0] qmul(logic signed [31:0] p,
                                                    logic signed [31:0] q);
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    prod = p * q;
    rnd  = (prod + 64'sd32768) >>> 16;
    return rnd[WIDE_W-1:0];
  endfunction

  // saturate a wide sum to 32 bits signed
  function automatic sat_t sat32(logic signed [WIDE_W-1:0] v);
    sat_t r;
    if ((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31])) begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic uinst_t mk(uop_e op, opsel_e a, opsel_e b, dst_e dst,
                                logic dbl, logic neg);
    uinst_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.dst = dst;
    u.dbl = dbl;
    u.neg = neg;
    return u;
  endfunction

  // Microprogram: gradient, one iteration, gradient at the new point, value.
  function automatic uinst_t ucode(logic [PC_W-1:0] pc);
    uinst_t u;
    unique case (pc)
      // gradient g1 = 2a*x1 + c*x2 + d, g2 = c*x1 + 2b*x2 + e
      7'd0, 7'd54:  u = mk(UOP_LDA, SEL_CD, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd1, 7'd55:  u = mk(UOP_MUL, SEL_CA, SEL_X1, DST_X1, 1'b0, 1'b0);
      7'd2, 7'd56:  u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b1, 1'b0);
      7'd3, 7'd57:  u = mk(UOP_MUL, SEL_CC, SEL_X2, DST_X1, 1'b0, 1'b0);
      7'd4, 7'd58:  u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd5, 7'd59:  u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_G1, 1'b0, 1'b0);
      7'd6, 7'd60:  u = mk(UOP_LDA, SEL_CE, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd7, 7'd61:  u = mk(UOP_MUL, SEL_CC, SEL_X1, DST_X1, 1'b0, 1'b0);
      7'd8, 7'd62:  u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd9, 7'd63:  u = mk(UOP_MUL, SEL_CB, SEL_X2, DST_X1, 1'b0, 1'b0);
      7'd10, 7'd64: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b1, 1'b0);
      7'd11, 7'd65: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_G2, 1'b0, 1'b0);
      // g.g and beta
      7'd12: u = mk(UOP_LDA, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd13: u = mk(UOP_MUL, SEL_G1, SEL_G1, DST_X1, 1'b0, 1'b0);
      7'd14: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd15: u = mk(UOP_MUL, SEL_G2, SEL_G2, DST_X1, 1'b0, 1'b0);
      7'd16: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd17: u = mk(UOP_STGG, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd18: u = mk(UOP_DIVB, SEL_ZERO, SEL_ZERO, DST_BETA, 1'b0, 1'b0);
      // direction
      7'd19: u = mk(UOP_LDA, SEL_G1, SEL_ZERO, DST_X1, 1'b0, 1'b1);
      7'd20: u = mk(UOP_MUL, SEL_BETA, SEL_D1, DST_X1, 1'b0, 1'b0);
      7'd21: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd22: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_D1, 1'b0, 1'b0);
      7'd23: u = mk(UOP_LDA, SEL_G2, SEL_ZERO, DST_X1, 1'b0, 1'b1);
      7'd24: u = mk(UOP_MUL, SEL_BETA, SEL_D2, DST_X1, 1'b0, 1'b0);
      7'd25: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd26: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_D2, 1'b0, 1'b0);
      // H times direction
      7'd27: u = mk(UOP_LDA, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd28: u = mk(UOP_MUL, SEL_CA, SEL_D1, DST_X1, 1'b0, 1'b0);
      7'd29: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b1, 1'b0);
      7'd30: u = mk(UOP_MUL, SEL_CC, SEL_D2, DST_X1, 1'b0, 1'b0);
      7'd31: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd32: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_H1, 1'b0, 1'b0);
      7'd33: u = mk(UOP_LDA, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd34: u = mk(UOP_MUL, SEL_CC, SEL_D1, DST_X1, 1'b0, 1'b0);
      7'd35: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd36: u = mk(UOP_MUL, SEL_CB, SEL_D2, DST_X1, 1'b0, 1'b0);
      7'd37: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b1, 1'b0);
      7'd38: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_H2, 1'b0, 1'b0);
      // curvature and step length
      7'd39: u = mk(UOP_LDA, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd40: u = mk(UOP_MUL, SEL_D1, SEL_H1, DST_X1, 1'b0, 1'b0);
      7'd41: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd42: u = mk(UOP_MUL, SEL_D2, SEL_H2, DST_X1, 1'b0, 1'b0);
      7'd43: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd44: u = mk(UOP_STDEN, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd45: u = mk(UOP_DIVA, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      // point update
      7'd46: u = mk(UOP_LDA, SEL_X1, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd47: u = mk(UOP_MUL, SEL_ALPHA, SEL_D1, DST_X1, 1'b0, 1'b0);
      7'd48: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd49: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd50: u = mk(UOP_LDA, SEL_X2, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd51: u = mk(UOP_MUL, SEL_ALPHA, SEL_D2, DST_X1, 1'b0, 1'b0);
      7'd52: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd53: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_X2, 1'b0, 1'b0);
      7'd66: u = mk(UOP_CHK, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      // function value at the converged point
      7'd67: u = mk(UOP_LDA, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd68: u = mk(UOP_MUL, SEL_X1, SEL_X1, DST_X1, 1'b0, 1'b0);
      7'd69: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd70: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_H1, 1'b0, 1'b0);
      7'd71: u = mk(UOP_LDA, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd72: u = mk(UOP_MUL, SEL_X2, SEL_X2, DST_X1, 1'b0, 1'b0);
      7'd73: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd74: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_H2, 1'b0, 1'b0);
      7'd75: u = mk(UOP_LDA, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd76: u = mk(UOP_MUL, SEL_X1, SEL_X2, DST_X1, 1'b0, 1'b0);
      7'd77: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd78: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_BETA, 1'b0, 1'b0);
      7'd79: u = mk(UOP_LDA, SEL_CF, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd80: u = mk(UOP_MUL, SEL_CA, SEL_H1, DST_X1, 1'b0, 1'b0);
      7'd81: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd82: u = mk(UOP_MUL, SEL_CB, SEL_H2, DST_X1, 1'b0, 1'b0);
      7'd83: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd84: u = mk(UOP_MUL, SEL_CC, SEL_BETA, DST_X1, 1'b0, 1'b0);
      7'd85: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd86: u = mk(UOP_MUL, SEL_CD, SEL_X1, DST_X1, 1'b0, 1'b0);
      7'd87: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd88: u = mk(UOP_MUL, SEL_CE, SEL_X2, DST_X1, 1'b0, 1'b0);
      7'd89: u = mk(UOP_ADD, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      7'd90: u = mk(UOP_ST, SEL_ZERO, SEL_ZERO, DST_MINV, 1'b0, 1'b0);
      7'd91: u = mk(UOP_EMIT, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
      default: u = mk(UOP_NOP, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
    endcase
    return u;
  endfunction

endpackage

>>> rtl/quadratic_conjugate_gradient_unit.sv
// Top level of the quadratic conjugate gradient unit: configuration registers,
// output register, controller and datapath. Depends on qcg_pkg, qcg_ctrl, qcg_dp.
//
// Each accepted start point runs Fletcher-Reeves iterations on the configured
// quadratic and sends one result per iteration until convergence or the limit.
// One item is worked on at a time. After setup, each iteration runs 55
// microprogram steps on the shared multiplier and accumulator, two divisions
// (beta and step length) that each hold the controller on the one bit-serial
// divider, and the load of the output register, which waits while the output
// register stays full. A skipped beta or a zero denominator does not start the
// divider. A converged point also runs the function value steps. The next start
// point is accepted as soon as the last result sits in the output register.
module quadratic_conjugate_gradient_unit import qcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  coef_t           coef_q;
  logic [IT_W-1:0] limit_q;
  logic            out_valid_q;
  out_t            out_q;

  cmd_t               cmd;
  status_t            status;
  emit_t              emit;
  logic               out_free;
  logic signed [31:0] x1, x2, alpha, minv;
  logic               fault;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.a   <= 32'sd131072;
      coef_q.b   <= 32'sd65536;
      coef_q.c   <= 32'sd131072;
      coef_q.d   <= 32'sd65536;
      coef_q.e   <= -32'sd65536;
      coef_q.f   <= 32'sd0;
      coef_q.tol <= 31'd655;
      limit_q    <= IT_W'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COEF_A:          coef_q.a   <= cfg_wdata_i;
        REG_COEF_B:          coef_q.b   <= cfg_wdata_i;
        REG_COEF_C:          coef_q.c   <= cfg_wdata_i;
        REG_COEF_D:          coef_q.d   <= cfg_wdata_i;
        REG_COEF_E:          coef_q.e   <= cfg_wdata_i;
        REG_COEF_F:          coef_q.f   <= cfg_wdata_i;
        REG_ITERATION_LIMIT: limit_q    <= cfg_wdata_i[IT_W-1:0];
        REG_TOLERANCE:       coef_q.tol <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  qcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .limit_i    (limit_q),
    .status_i   (status),
    .cmd_o      (cmd),
    .emit_o     (emit)
  );

  qcg_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .coef_i    (coef_q),
    .status_o  (status),
    .x1_o      (x1),
    .x2_o      (x2),
    .alpha_o   (alpha),
    .minv_o    (minv),
    .fault_o   (fault)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.emit) begin
      out_q.iteration     <= emit.iteration;
      out_q.point_x1      <= x1;
      out_q.point_x2      <= x2;
      out_q.step_length   <= alpha;
      out_q.converged     <= emit.converged;
      out_q.minimum_value <= emit.converged ? minv : 32'sd0;
      out_q.fault         <= fault;
      out_q.last          <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.emit |-> out_free) else $error("result loaded over a pending transfer");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accepted while busy");
  a_conv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.converged) |-> out_data_o.last)
    else $error("converged result not last");
  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.emit |-> (emit.iteration != '0 && emit.iteration <= IT_W'(MAX_ITERATIONS)))
    else $error("iteration number out of range");

endmodule

>>> rtl/qcg_div.sv
// Signed Q16.16 divider, one quotient bit per cycle, saturating result.
// Depends on qcg_pkg for widths.
module qcg_div import qcg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [WIDE_W-1:0] num_i,
  input  logic signed [WIDE_W-1:0] den_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic signed [31:0]       quo_o,
  output logic                     ovf_o
);

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]  num_q;
  logic [WIDE_W-1:0] dv_q, rem_q;
  logic [32:0]       quo_q;
  logic              ovf_q, neg_q;

  logic [WIDE_W-1:0] nmag, dmag;
  logic [WIDE_W:0]   rem_s, rem_n;
  logic              ge;
  logic [32:0]       quo_neg;

  assign nmag = num_i[WIDE_W-1] ? WIDE_W'(-num_i) : WIDE_W'(num_i);
  assign dmag = den_i[WIDE_W-1] ? WIDE_W'(-den_i) : WIDE_W'(den_i);

  // one restoring step
  assign rem_s = {rem_q, num_q[NUM_W-1]};
  assign ge    = rem_s >= {1'b0, dv_q};
  assign rem_n = ge ? rem_s - {1'b0, dv_q} : rem_s;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DCNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {nmag, 16'h0000};
      dv_q  <= dmag;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_i[WIDE_W-1] ^ den_i[WIDE_W-1];
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_n[WIDE_W-1:0];
      quo_q <= {quo_q[31:0], ge};
      ovf_q <= ovf_q | quo_q[32];
    end
  end

  // saturate the magnitude with the sign applied
  assign quo_neg = -quo_q;
  always_comb begin
    if (neg_q) begin
      ovf_o = ovf_q || (quo_q > 33'h0_8000_0000);
      quo_o = ovf_o ? 32'sh8000_0000 : quo_neg[31:0];
    end else begin
      ovf_o = ovf_q || (quo_q > 33'h0_7fff_ffff);
      quo_o = ovf_o ? 32'sh7fff_ffff : quo_q[31:0];
    end
  end

  assign busy_o = busy_q | done_q;
  assign done_o = done_q;

endmodule

>>> rtl/qcg_dp.sv
// Datapath: iterate registers, shared multiplier, wide accumulator, divider.
// Depends on qcg_pkg and qcg_div.
module qcg_dp import qcg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  in_t                in_data_i,
  input  coef_t              coef_i,
  output status_t            status_o,
  output logic signed [31:0] x1_o,
  output logic signed [31:0] x2_o,
  output logic signed [31:0] alpha_o,
  output logic signed [31:0] minv_o,
  output logic               fault_o
);

  logic signed [31:0] x1_q, x2_q, g1_q, g2_q, d1_q, d2_q, h1_q, h2_q;
  logic signed [31:0] beta_q, alpha_q, minv_q;
  logic signed [WIDE_W-1:0] acc_q, prod_q, gg_q, ggp_q, den_q;
  logic flt_q, div_alpha_q;

  logic signed [31:0] op_a, op_b;
  logic signed [WIDE_W-1:0] acc_ext;
  sat_t st;
  logic div_start;
  logic signed [WIDE_W-1:0] div_den;
  logic div_busy, div_done, div_ovf;
  logic signed [31:0] div_quo;
  logic [32:0] ag1, ag2;
  logic [33:0] gsum;

  // operand selection
  always_comb begin
    unique case (cmd_i.u.a)
      SEL_X1:    op_a = x1_q;
      SEL_X2:    op_a = x2_q;
      SEL_G1:    op_a = g1_q;
      SEL_G2:    op_a = g2_q;
      SEL_D1:    op_a = d1_q;
      SEL_D2:    op_a = d2_q;
      SEL_H1:    op_a = h1_q;
      SEL_H2:    op_a = h2_q;
      SEL_BETA:  op_a = beta_q;
      SEL_ALPHA: op_a = alpha_q;
      SEL_CA:    op_a = coef_i.a;
      SEL_CB:    op_a = coef_i.b;
      SEL_CC:    op_a = coef_i.c;
      SEL_CD:    op_a = coef_i.d;
      SEL_CE:    op_a = coef_i.e;
      SEL_CF:    op_a = coef_i.f;
      default:   op_a = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.u.b)
      SEL_X1:    op_b = x1_q;
      SEL_X2:    op_b = x2_q;
      SEL_G1:    op_b = g1_q;
      SEL_G2:    op_b = g2_q;
      SEL_D1:    op_b = d1_q;
      SEL_D2:    op_b = d2_q;
      SEL_H1:    op_b = h1_q;
      SEL_H2:    op_b = h2_q;
      SEL_BETA:  op_b = beta_q;
      SEL_ALPHA: op_b = alpha_q;
      SEL_CA:    op_b = coef_i.a;
      SEL_CB:    op_b = coef_i.b;
      SEL_CC:    op_b = coef_i.c;
      SEL_CD:    op_b = coef_i.d;
      SEL_CE:    op_b = coef_i.e;
      SEL_CF:    op_b = coef_i.f;
      default:   op_b = '0;
    endcase
  end

  assign acc_ext = {{(WIDE_W-32){op_a[31]}}, op_a};
  assign st      = sat32(acc_q);

  // start the divider unless the denominator is zero or beta is skipped
  always_comb begin
    div_start = 1'b0;
    div_den   = den_q;
    if (cmd_i.u.op == UOP_DIVB) begin
      div_den   = ggp_q;
      div_start = !cmd_i.first && (ggp_q != '0);
    end else if (cmd_i.u.op == UOP_DIVA) begin
      div_start = (den_q != '0);
    end
  end

  qcg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (gg_q),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf)
  );

  // execute one command
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q  <= in_data_i.start_x1;
      x2_q  <= in_data_i.start_x2;
      d1_q  <= '0;
      d2_q  <= '0;
      gg_q  <= '0;
      flt_q <= 1'b0;
    end else if (div_done) begin
      if (div_alpha_q) alpha_q <= div_quo;
      else             beta_q  <= div_quo;
      flt_q <= flt_q | div_ovf;
    end else begin
      unique case (cmd_i.u.op)
        UOP_LDA: acc_q  <= cmd_i.u.neg ? -acc_ext : acc_ext;
        UOP_MUL: prod_q <= qmul(op_a, op_b);
        UOP_ADD: acc_q  <= acc_q + (cmd_i.u.dbl ? (prod_q <<< 1) : prod_q);
        UOP_ST: begin
          flt_q <= flt_q | st.ovf;
          unique case (cmd_i.u.dst)
            DST_X1:   x1_q   <= st.val;
            DST_X2:   x2_q   <= st.val;
            DST_G1:   g1_q   <= st.val;
            DST_G2:   g2_q   <= st.val;
            DST_D1:   d1_q   <= st.val;
            DST_D2:   d2_q   <= st.val;
            DST_H1:   h1_q   <= st.val;
            DST_H2:   h2_q   <= st.val;
            DST_BETA: beta_q <= st.val;
            DST_MINV: minv_q <= st.val;
            default:  ;
          endcase
        end
        UOP_STGG: begin
          ggp_q <= gg_q;
          gg_q  <= acc_q;
        end
        UOP_STDEN: den_q <= acc_q;
        UOP_DIVB: begin
          div_alpha_q <= 1'b0;
          if (!div_start) beta_q <= '0;
          if (!cmd_i.first && (ggp_q == '0)) flt_q <= 1'b1;
        end
        UOP_DIVA: begin
          div_alpha_q <= 1'b1;
          if (!div_start) begin
            alpha_q <= '0;
            flt_q   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // gradient test
  assign ag1  = g1_q[31] ? -{g1_q[31], g1_q} : {1'b0, g1_q};
  assign ag2  = g2_q[31] ? -{g2_q[31], g2_q} : {1'b0, g2_q};
  assign gsum = {1'b0, ag1} + {1'b0, ag2};

  assign status_o.div_busy = div_busy;
  assign status_o.conv     = gsum <= {3'b000, coef_i.tol};

  assign x1_o    = x1_q;
  assign x2_o    = x2_q;
  assign alpha_o = alpha_q;
  assign minv_o  = minv_q;
  assign fault_o = flt_q;

endmodule

>>> rtl/qcg_ctrl.sv
// Controller: state machine and microprogram sequencer for the iterations.
// Depends on qcg_pkg for the command types and the microprogram.
module qcg_ctrl import qcg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  input  logic [IT_W-1:0] limit_i,
  input  status_t         status_i,
  output cmd_t            cmd_o,
  output emit_t           emit_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [IT_W-1:0] it_q, it_d, lim_q, lim_d;
  logic            conv_q, conv_d, last_q, last_d;
  uinst_t          ui;

  assign ui = ucode(pc_q);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    it_d    = it_q;
    lim_d   = lim_q;
    conv_d  = conv_q;
    last_d  = last_q;
    cmd_o.u     = mk(UOP_NOP, SEL_ZERO, SEL_ZERO, DST_X1, 1'b0, 1'b0);
    cmd_o.first = (it_q == IT_W'(1));
    cmd_o.load  = 1'b0;
    emit_o.emit      = 1'b0;
    emit_o.iteration = it_q;
    emit_o.converged = conv_q;
    emit_o.last      = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d       = '0;
          it_d       = IT_W'(1);
          if (limit_i == '0)                          lim_d = IT_W'(1);
          else if (limit_i > IT_W'(MAX_ITERATIONS))   lim_d = IT_W'(MAX_ITERATIONS);
          else                                        lim_d = limit_i;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        unique case (ui.op)
          UOP_CHK: begin
            // branch to the function value, or report the point
            if (status_i.conv) begin
              pc_d = PC_VAL;
            end else begin
              conv_d  = 1'b0;
              last_d  = (it_q == lim_q);
              state_d = S_EMIT;
            end
          end
          UOP_EMIT: begin
            conv_d  = 1'b1;
            last_d  = 1'b1;
            state_d = S_EMIT;
          end
          UOP_DIVB, UOP_DIVA: begin
            cmd_o.u = ui;
            pc_d    = pc_q + 1'b1;
            state_d = S_DIV;
          end
          default: begin
            cmd_o.u = ui;
            pc_d    = pc_q + 1'b1;
          end
        endcase
      end
      S_DIV: begin
        if (!status_i.div_busy) state_d = S_RUN;
      end
      S_EMIT: begin
        // hold until the output register can take the transfer
        if (out_free_i) begin
          emit_o.emit = 1'b1;
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            it_d    = it_q + 1'b1;
            pc_d    = PC_ITER;
            state_d = S_RUN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      it_q    <= '0;
      lim_q   <= '0;
      conv_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      it_q    <= it_d;
      lim_q   <= lim_d;
      conv_q  <= conv_d;
      last_q  <= last_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> dv/quadratic_conjugate_gradient_unit_tb.sv
// Self-checking testbench for quadratic_conjugate_gradient_unit: a queue-fed driver,
// a monitor with a fixed-point Fletcher-Reeves predictor, and config phases.
// Depends on qcg_pkg and the unit's RTL.
module quadratic_conjugate_gradient_unit_tb;
  import qcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  in_t               in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_t              out_data_o;
  logic              cfg_we_i;
  logic [CIDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;

  quadratic_conjugate_gradient_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // shadow of the configuration registers
  int        ca, cb, cc, cd, ce, cf;
  logic [6:0]  cfg_limit;
  logic [30:0] cfg_tol;

  in_t  start_q[$];     // start points waiting to be offered
  out_t iterate_q[$];   // predicted iterates, oldest first

  int   err_cnt, start_cnt, point_cnt, conv_cnt, fault_cnt;
  bit   in_took, out_took, hold_rx, quiet;
  logic [4:0] send_gap, rx_wait;

  // Q16.16 product rounded half up
  function automatic longint rq(input int p, input int q);
    longint t;
    t = longint'(p) * longint'(q);
    return (t + 32768) >>> 16;
  endfunction

  function automatic int clamp32(input longint v, inout bit flt);
    if (v > 64'sd2147483647) begin
      flt = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      flt = 1'b1;
      return 32'sh8000_0000;
    end
    return int'(v);
  endfunction

  // Q16.16 quotient truncated toward zero, saturated
  function automatic int qdiv(input longint n, input longint dv, inout bit flt);
    longint unsigned un, ud, q, r;
    bit neg;
    neg = (n < 0) != (dv < 0);
    un = (n < 0) ? longint'(-n) : n;
    ud = (dv < 0) ? longint'(-dv) : dv;
    q = un / ud;
    r = un % ud;
    if (q > 64'h8000) q = 64'h8000_0001;
    else begin
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 64'd1;
        end
      end
    end
    if (neg) begin
      if (q > 64'h8000_0000) begin
        flt = 1'b1;
        return 32'sh8000_0000;
      end
      return int'(-longint'(q));
    end
    if (q > 64'h7fff_ffff) begin
      flt = 1'b1;
      return 32'sh7fff_ffff;
    end
    return int'(q);
  endfunction

  task automatic grad(input int x1, input int x2, output int g1, output int g2,
                      inout bit flt);
    g1 = clamp32(2 * rq(ca, x1) + rq(cc, x2) + cd, flt);
    g2 = clamp32(rq(cc, x1) + 2 * rq(cb, x2) + ce, flt);
  endtask

  function automatic int quad_value(input int x1, input int x2, inout bit flt);
    int s11, s22, s12;
    s11 = clamp32(rq(x1, x1), flt);
    s22 = clamp32(rq(x2, x2), flt);
    s12 = clamp32(rq(x1, x2), flt);
    return clamp32(rq(ca, s11) + rq(cb, s22) + rq(cc, s12) + rq(cd, x1) + rq(ce, x2)
                   + longint'(cf), flt);
  endfunction

  // Run the minimizer from one start point and queue every iterate it emits
  task automatic solve_start(input in_t s);
    int x1, x2, g1, g2, d1, d2, beta, alpha, h1, h2, minv, lim;
    longint gg, gg_prev, den, gsum;
    bit flt, conv, lst;
    out_t r;
    x1 = s.start_x1;
    x2 = s.start_x2;
    d1 = 0;
    d2 = 0;
    gg_prev = 0;
    flt = 1'b0;
    lim = cfg_limit;
    if (lim < 1) lim = 1;
    if (lim > MAX_ITERATIONS) lim = MAX_ITERATIONS;
    grad(x1, x2, g1, g2, flt);
    for (int it = 1; it <= lim; it++) begin
      gg = rq(g1, g1) + rq(g2, g2);
      beta = 0;
      alpha = 0;
      minv = 0;
      if (it > 1) begin
        if (gg_prev == 0) flt = 1'b1;
        else beta = qdiv(gg, gg_prev, flt);
      end
      d1 = clamp32(-longint'(g1) + rq(beta, d1), flt);
      d2 = clamp32(-longint'(g2) + rq(beta, d2), flt);
      h1 = clamp32(2 * rq(ca, d1) + rq(cc, d2), flt);
      h2 = clamp32(rq(cc, d1) + 2 * rq(cb, d2), flt);
      den = rq(d1, h1) + rq(d2, h2);
      if (den == 0) flt = 1'b1;
      else alpha = qdiv(gg, den, flt);
      x1 = clamp32(longint'(x1) + rq(alpha, d1), flt);
      x2 = clamp32(longint'(x2) + rq(alpha, d2), flt);
      gg_prev = gg;
      grad(x1, x2, g1, g2, flt);
      gsum = (g1 < 0 ? -longint'(g1) : longint'(g1)) + (g2 < 0 ? -longint'(g2) : longint'(g2));
      conv = gsum <= longint'(cfg_tol);
      if (conv) minv = quad_value(x1, x2, flt);
      lst = conv || (it == lim);
      r.iteration     = it[6:0];
      r.point_x1      = x1;
      r.point_x2      = x2;
      r.step_length   = alpha;
      r.converged     = conv;
      r.minimum_value = minv;
      r.fault         = flt;
      r.last          = lst;
      iterate_q.push_back(r);
      if (lst) break;
    end
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, field, got, want);
    err_cnt++;
  endtask

  function automatic logic [4:0] draw_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 5'd0;
    return 5'($urandom_range(0, 16));
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor: sample both handshakes, predict on input, compare on output
  always @(posedge clk_i) begin
    in_took  = rst_ni && in_valid_i && in_ready_o;
    out_took = rst_ni && out_valid_o && out_ready_i;
    if (in_took) begin
      start_cnt++;
      solve_start(in_data_i);
    end
    if (out_took) begin
      if (iterate_q.size() == 0) begin
        report("unexpected result", out_data_o.point_x1, 32'h0);
      end else begin
        out_t w;
        w = iterate_q.pop_front();
        point_cnt++;
        if (out_data_o.converged) conv_cnt++;
        if (out_data_o.fault) fault_cnt++;
        if (out_data_o.iteration !== w.iteration)
          report("iteration", 32'(out_data_o.iteration), 32'(w.iteration));
        if (out_data_o.point_x1 !== w.point_x1)
          report("point_x1", out_data_o.point_x1, w.point_x1);
        if (out_data_o.point_x2 !== w.point_x2)
          report("point_x2", out_data_o.point_x2, w.point_x2);
        if (out_data_o.step_length !== w.step_length)
          report("step_length", out_data_o.step_length, w.step_length);
        if (out_data_o.converged !== w.converged)
          report("converged", 32'(out_data_o.converged), 32'(w.converged));
        if (out_data_o.minimum_value !== w.minimum_value)
          report("minimum_value", out_data_o.minimum_value, w.minimum_value);
        if (out_data_o.fault !== w.fault)
          report("fault", 32'(out_data_o.fault), 32'(w.fault));
        if (out_data_o.last !== w.last)
          report("last", 32'(out_data_o.last), 32'(w.last));
      end
    end
  end

  // driver: hold until transfer, then idle a drawn gap, then offer the next start point
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_took) begin
        // hold
      end else if (send_gap != 0) begin
        send_gap   <= send_gap - 5'd1;
        in_valid_i <= 1'b0;
      end else if (start_q.size() != 0) begin
        in_data_i  <= start_q.pop_front();
        in_valid_i <= 1'b1;
        send_gap   <= draw_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall a drawn number of cycles after each transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) rx_wait = draw_gap();
      out_ready_i <= (rx_wait == 0) && !hold_rx;
      if (rx_wait != 0) rx_wait = rx_wait - 5'd1;
    end
  end

  // one long receiver hold-off so the unit backs up and stalls its input
  initial begin
    hold_rx = 1'b0;
    while (start_cnt < 60) @(negedge clk_i);
    hold_rx <= 1'b1;
    repeat (3000) @(negedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #400ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic write_reg(input cfg_reg_e r, input logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = r;
    cfg_wdata_i = v;
    case (r)
      REG_COEF_A:          ca = v;
      REG_COEF_B:          cb = v;
      REG_COEF_C:          cc = v;
      REG_COEF_D:          cd = v;
      REG_COEF_E:          ce = v;
      REG_COEF_F:          cf = v;
      REG_ITERATION_LIMIT: cfg_limit = v[6:0];
      default:             cfg_tol = v[30:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_all(input int a, input int b, input int c, input int d, input int e,
                         input int f, input logic [31:0] lim, input logic [31:0] tol);
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_COEF_D, d);
    write_reg(REG_COEF_E, e);
    write_reg(REG_COEF_F, f);
    write_reg(REG_ITERATION_LIMIT, lim);
    write_reg(REG_TOLERANCE, tol);
  endtask

  // wait until every queued start point is taken and every iterate is back
  task automatic drain();
    while (start_q.size() != 0 || in_valid_i || iterate_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic offer(input logic [31:0] x1, input logic [31:0] x2);
    in_t s;
    s.start_x1 = x1;
    s.start_x2 = x2;
    start_q.push_back(s);
  endtask

  // stimulus
  initial begin
    int lims[10];
    int n, a, b, c;
    lims = '{1, 4, 64, 8, 0, 12, 3, 127, 6, 5};
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_COEF_A;
    cfg_wdata_i = '0;
    send_gap = '0;
    rx_wait = '0;
    quiet = 1'b0;
    ca = 131072; cb = 65536; cc = 131072; cd = 65536; ce = -65536; cf = 0;
    cfg_limit = 7'd10;
    cfg_tol = 31'd655;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: extremes of the start point
    offer(32'h0, 32'h0);
    offer(32'h7fff_ffff, 32'h7fff_ffff);
    offer(32'h8000_0000, 32'h8000_0000);
    offer(32'h8000_0000, 32'h7fff_ffff);
    offer(32'h0001_0000, 32'hffff_0000);
    offer(32'h5555_5555, 32'haaaa_aaaa);
    offer(32'haaaa_aaaa, 32'h5555_5555);
    drain();
    // flat surface with a tiny slope: zero curvature, then zero previous g.g
    set_all(0, 0, 0, 100, 0, 32'h7fff_ffff, 3, 0);
    offer(32'h0, 32'h0);
    offer(32'h1234_5678, 32'hffff_ffff);
    drain();
    // exact minimum at the start: zero gradient
    set_all(65536, 65536, 0, 0, 0, -5, 5, 655);
    offer(32'h0, 32'h0);
    drain();
    // negative curvature, limit above the maximum, then with zero tolerance
    set_all(-65536, 32768, 16384, 65536, 65536, 32'h8000_0000, 127, 32'h7fff_ffff);
    offer(32'h0003_0000, 32'hfffe_0000);
    drain();
    write_reg(REG_TOLERANCE, 0);
    offer(32'h0003_0000, 32'hfffe_0000);
    drain();
    // extreme coefficients, limit zero
    set_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h7fff_ffff, 0, 655);
    offer(32'h0001_0000, 32'h0001_0000);
    offer(32'h8000_0000, 32'h0);
    drain();

    // random phases, one setting each
    for (int p = 0; p < 10; p++) begin
      quiet = (p == 3) || (p == 7);
      if (p % 3 == 2) begin
        set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                {25'($urandom_range(0, 33554431)), 7'(lims[p])}, $urandom);
      end else begin
        a = $urandom_range(16384, 8 * 65536);
        b = $urandom_range(16384, 8 * 65536);
        c = $urandom_range(0, (a < b) ? a : b);
        if ($urandom_range(0, 1)) c = -c;
        set_all(a, b, c, $urandom_range(0, 32 * 65536) - 16 * 65536,
                $urandom_range(0, 32 * 65536) - 16 * 65536, $urandom,
                {25'($urandom_range(0, 33554431)), 7'(lims[p])},
                ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 1 << 20));
      end
      n = (lims[p] >= 64) ? 10 : 58;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) offer($urandom, $urandom);
        else offer($urandom_range(0, 32 * 65536) - 16 * 65536,
                   $urandom_range(0, 32 * 65536) - 16 * 65536);
      end
      drain();
    end

    repeat (300) @(negedge clk_i);
    $display("Ran %0d start points through 16 settings, %0d iterates checked.",
             start_cnt, point_cnt);
    $display("%0d converged, %0d with fault set, %0d mismatches.",
             conv_cnt, fault_cnt, err_cnt);
    if (err_cnt == 0 && iterate_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
